// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the RTL. Both are empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// A property must hold at every rising clock edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// A condition must never be true at a rising clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif

`endif

// ===== hw/rtl/bsi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsi_pkg
// Types and constants of the radix string-to-integer converter.
// ----------------------------------------------------------------------------
package bsi_pkg;

    // Alphabet size and derived widths
    localparam int MAX_RADIX = 16;
    localparam int DIGIT_W   = $clog2(MAX_RADIX);
    localparam int LEN_W     = 5;
    localparam int ACC_W     = 32;
    localparam int CHAR_W    = 8;
    localparam int ALPHA_W   = 64;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_LEN   = 2'd2;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;

    // Queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Input transfer
    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              is_last;
    } bsi_in_t;

    // Result transfer
    typedef struct packed {
        logic signed [ACC_W-1:0] value;
        logic                    base_invalid;
    } bsi_out_t;

    // Classified byte, front to back
    typedef struct packed {
        logic               is_space;
        logic               is_plus;
        logic               is_minus;
        logic               is_digit;
        logic [DIGIT_W-1:0] digit;
        logic [LEN_W-1:0]   base_len;
        logic               is_term;
        logic               base_invalid;
    } bsi_rec_t;

endpackage

// ===== hw/rtl/bsi_queue.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// bsi_queue
// Short FIFO of classified bytes between the front and back parts.
// ----------------------------------------------------------------------------
module bsi_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  bsi_pkg::bsi_rec_t push_data,
    output logic              full,
    input  logic              pop,
    output bsi_pkg::bsi_rec_t pop_data,
    output logic              not_empty
);
    import bsi_pkg::*;

    bsi_rec_t           mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    // Pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    `ASSERT_NEVER(a_q_overfill, clk, rst_n, count_reg > Q_CNT_W'(Q_DEPTH), "queue count above depth")
    `ASSERT_NEVER(a_q_push_full, clk, rst_n, push && full, "push into full queue")
    `ASSERT_NEVER(a_q_pop_empty, clk, rst_n, pop && !not_empty, "pop from empty queue")

endmodule

// ===== hw/rtl/bsi_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsi_front
// Holds the alphabet registers, checks the alphabet and classifies each byte.
// ----------------------------------------------------------------------------
module bsi_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bsi_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bsi_pkg::ALPHA_W-1:0]       cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  bsi_pkg::bsi_in_t                  in_data,
    input  logic                              q_full,
    output logic                              q_push,
    output bsi_pkg::bsi_rec_t                 q_data
);
    import bsi_pkg::*;

    logic [ALPHA_W-1:0] alpha_low_reg;
    logic [ALPHA_W-1:0] alpha_high_reg;
    logic [LEN_W-1:0]   base_len_reg;
    logic               alpha_invalid;

    logic [2*ALPHA_W-1:0] alphabet;
    logic [LEN_W-1:0]     used_len;
    logic                 hit;
    logic [DIGIT_W-1:0]   hit_idx;
    logic [CHAR_W-1:0]    c;

    assign cfg_ready = 1'b1;
    assign in_stall  = q_full;
    assign q_push    = in_valid && !q_full;
    assign alphabet  = {alpha_high_reg, alpha_low_reg};
    assign used_len  = (base_len_reg > LEN_W'(MAX_RADIX)) ? LEN_W'(MAX_RADIX) : base_len_reg;
    assign c         = in_data.char_code;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_low_reg  <= '0;
            alpha_high_reg <= '0;
            base_len_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_ALPHA_LOW:  alpha_low_reg  <= cfg_data;
                REG_ALPHA_HIGH: alpha_high_reg <= cfg_data;
                REG_BASE_LEN:   base_len_reg   <= cfg_data[LEN_W-1:0];
                default:        ;
            endcase
        end
    end

    // Alphabet check: length range, forbidden characters, repeats
    always_comb
    begin
        alpha_invalid = (base_len_reg < LEN_W'(2)) || (base_len_reg > LEN_W'(MAX_RADIX));
        for (int k = 0; k < MAX_RADIX; k++)
        begin
            if (LEN_W'(k) < base_len_reg)
            begin
                if (alphabet[8*k +: 8] == CH_NUL || alphabet[8*k +: 8] == CH_PLUS ||
                    alphabet[8*k +: 8] == CH_MINUS)
                begin
                    alpha_invalid = 1'b1;
                end
                for (int m = k + 1; m < MAX_RADIX; m++)
                begin
                    if (LEN_W'(m) < base_len_reg && alphabet[8*m +: 8] == alphabet[8*k +: 8])
                    begin
                        alpha_invalid = 1'b1;
                    end
                end
            end
        end
    end

    // Digit lookup, lowest matching index wins
    always_comb
    begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int k = MAX_RADIX - 1; k >= 0; k--)
        begin
            if (LEN_W'(k) < used_len && alphabet[8*k +: 8] == c)
            begin
                hit     = 1'b1;
                hit_idx = DIGIT_W'(k);
            end
        end
    end

    // Classified record
    always_comb
    begin
        q_data.is_space     = (c >= CH_TAB && c <= CH_CR) || (c == CH_SPACE);
        q_data.is_plus      = (c == CH_PLUS);
        q_data.is_minus     = (c == CH_MINUS);
        q_data.is_digit     = hit && (c != CH_NUL);
        q_data.digit        = hit_idx;
        q_data.base_len     = base_len_reg;
        q_data.is_term      = (c == CH_NUL) || in_data.is_last;
        q_data.base_invalid = alpha_invalid;
    end

endmodule

// ===== hw/rtl/bsi_back.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// bsi_back
// Runs the parse phases, accumulates digits and registers the result.
// ----------------------------------------------------------------------------
module bsi_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_not_empty,
    input  bsi_pkg::bsi_rec_t q_data,
    output logic              q_pop,
    output logic              out_valid,
    input  logic              out_stall,
    output bsi_pkg::bsi_out_t out_data
);
    import bsi_pkg::*;

    localparam logic [1:0] PH_SPACE = 2'd0;
    localparam logic [1:0] PH_SIGN  = 2'd1;
    localparam logic [1:0] PH_DIGIT = 2'd2;
    localparam logic [1:0] PH_STOP  = 2'd3;

    logic [1:0]       phase_reg, phase_next;
    logic             neg_reg, neg_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [ACC_W-1:0] prod;
    logic             out_valid_reg;
    bsi_out_t         out_reg;
    bsi_out_t         result;
    logic             out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign q_pop     = q_not_empty && (!q_data.is_term || out_free);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign prod      = acc_reg * ACC_W'(q_data.base_len);

    // Phase walk for one byte
    always_comb
    begin
        phase_next = phase_reg;
        neg_next   = neg_reg;
        acc_next   = acc_reg;
        if (phase_next == PH_SPACE && !q_data.is_space)
        begin
            phase_next = PH_SIGN;
        end
        if (phase_next == PH_SIGN)
        begin
            if (q_data.is_plus || q_data.is_minus)
            begin
                neg_next = neg_reg ^ q_data.is_minus;
            end
            else
            begin
                phase_next = PH_DIGIT;
            end
        end
        if (phase_next == PH_DIGIT)
        begin
            if (!q_data.is_digit)
            begin
                phase_next = PH_STOP;
            end
            else
            begin
                acc_next = prod + ACC_W'(q_data.digit);
            end
        end
    end

    // Final value with sign, zero for an invalid alphabet
    always_comb
    begin
        result.base_invalid = q_data.base_invalid;
        if (q_data.base_invalid)
        begin
            result.value = '0;
        end
        else if (neg_next)
        begin
            result.value = $signed(-acc_next);
        end
        else
        begin
            result.value = $signed(acc_next);
        end
    end

    // Parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SPACE;
            neg_reg   <= 1'b0;
            acc_reg   <= '0;
        end
        else if (q_pop)
        begin
            if (q_data.is_term)
            begin
                phase_reg <= PH_SPACE;
                neg_reg   <= 1'b0;
                acc_reg   <= '0;
            end
            else
            begin
                phase_reg <= phase_next;
                neg_reg   <= neg_next;
                acc_reg   <= acc_next;
            end
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (q_pop && q_data.is_term)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop && q_data.is_term)
        begin
            out_reg <= result;
        end
    end

    `ASSERT_PROP(a_term_clears, clk, rst_n, q_pop && q_data.is_term |=> phase_reg == PH_SPACE && !neg_reg && acc_reg == '0, "state not cleared after terminator")
    `ASSERT_PROP(a_invalid_zero, clk, rst_n, out_valid_reg && out_reg.base_invalid |-> out_reg.value == '0, "invalid alphabet with nonzero value")
    `ASSERT_PROP(a_stop_holds, clk, rst_n, q_pop && !q_data.is_term && phase_reg == PH_STOP |=> $stable(acc_reg), "accumulator moved after stop")

endmodule

// ===== hw/rtl/base_string_to_integer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base_string_to_integer_unit
// Radix string-to-integer converter with a configurable digit alphabet.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one string byte per transfer (char_code, is_last). A transfer
//            with char_code 0 or is_last 1 ends the string.
//   out_*  : one result per string (value, base_invalid), on its last byte.
//   cfg_*  : register writes (0 alphabet_low, 1 alphabet_high, 2 base_length),
//            always ready; write only while no string is in progress.
// Throughput is one byte per cycle unless in_stall or a stalled result holds
// it: the front compares the byte against all sixteen alphabet characters at
// once and the back does one 32x5 multiply-add per cycle. A two-entry queue
// sits between them. The last byte passes through the queue entry and then
// the output register before its result is presented on out_valid.
// A stalled result holds in the output register; the back keeps consuming
// non-final bytes and stops only at the next final byte, and once the queue
// fills in_stall rises. Reset clears the alphabet registers, the parse state
// and the queue; no clearing pass is needed.
// ----------------------------------------------------------------------------
module base_string_to_integer_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bsi_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bsi_pkg::ALPHA_W-1:0]   cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  bsi_pkg::bsi_in_t              in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output bsi_pkg::bsi_out_t             out_data
);
    import bsi_pkg::*;

    logic     q_push;
    logic     q_full;
    logic     q_pop;
    logic     q_not_empty;
    bsi_rec_t q_wdata;
    bsi_rec_t q_rdata;

    bsi_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_wdata)
    );

    bsi_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_rdata),
        .not_empty (q_not_empty)
    );

    bsi_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_data      (q_rdata),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data)
    );

endmodule

// ===== tb/bsi_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsi_checker
// Watches the register, byte and result channels of the radix converter.
// It keeps its own copy of the alphabet registers and parse state, works
// out the result of every terminating byte, and compares the results that
// come out, in order, field by field.
// ----------------------------------------------------------------------------
module bsi_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [bsi_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bsi_pkg::ALPHA_W-1:0]   cfg_data,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  bsi_pkg::bsi_in_t              in_data,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  bsi_pkg::bsi_out_t             out_data,
    output int                            mismatches,
    output int                            results_owed
);
    import bsi_pkg::*;

    localparam logic [1:0] SCAN_BLANKS = 2'd0;
    localparam logic [1:0] SCAN_SIGNS  = 2'd1;
    localparam logic [1:0] SCAN_DIGITS = 2'd2;
    localparam logic [1:0] SCAN_DONE   = 2'd3;

    // Register copy
    logic [ALPHA_W-1:0] alpha_lo;
    logic [ALPHA_W-1:0] alpha_hi;
    logic [LEN_W-1:0]   radix;

    // Parse state
    logic [1:0]        scan;
    logic              negate;
    logic [ACC_W-1:0]  acc;

    bsi_out_t expected_q[$];
    bsi_out_t want;
    int       errors;

    function automatic logic [CHAR_W-1:0] alpha_char(input int k);
        logic [ALPHA_W-1:0] word;
        word = (k < 8) ? alpha_lo : alpha_hi;
        return word[(k % 8) * 8 +: 8];
    endfunction

    // First matching position among the characters in use, -1 if none
    function automatic int digit_value(input logic [CHAR_W-1:0] c);
        int n;
        n = (radix > MAX_RADIX) ? MAX_RADIX : int'(radix);
        for (int k = 0; k < n; k++)
            if (alpha_char(k) == c)
                return k;
        return -1;
    endfunction

    function automatic logic alphabet_ok();
        logic [CHAR_W-1:0] c;
        if (radix < 2 || radix > MAX_RADIX)
            return 1'b0;
        for (int k = 0; k < radix; k++)
        begin
            c = alpha_char(k);
            if (c == CH_NUL || c == CH_PLUS || c == CH_MINUS)
                return 1'b0;
            for (int m = k + 1; m < radix; m++)
                if (alpha_char(m) == c)
                    return 1'b0;
        end
        return 1'b1;
    endfunction

    // Advance the parse by one byte; queue a result when the string ends
    task automatic absorb_char(input bsi_in_t item);
        int       d;
        bsi_out_t res;
        logic     blank;
        blank = (item.char_code >= CH_TAB && item.char_code <= CH_CR) ||
                item.char_code == CH_SPACE;
        if (scan == SCAN_BLANKS && !blank)
            scan = SCAN_SIGNS;
        if (scan == SCAN_SIGNS)
        begin
            if (item.char_code == CH_MINUS)
                negate = !negate;
            else if (item.char_code != CH_PLUS)
                scan = SCAN_DIGITS;
        end
        if (scan == SCAN_DIGITS)
        begin
            d = (item.char_code == CH_NUL) ? -1 : digit_value(item.char_code);
            if (d < 0)
                scan = SCAN_DONE;
            else
                acc = acc * radix + ACC_W'(d);
        end
        if (item.char_code == CH_NUL || item.is_last)
        begin
            if (alphabet_ok())
            begin
                res.value        = negate ? (ACC_W'(0) - acc) : acc;
                res.base_invalid = 1'b0;
            end
            else
            begin
                res.value        = '0;
                res.base_invalid = 1'b1;
            end
            expected_q.push_back(res);
            scan   = SCAN_BLANKS;
            negate = 1'b0;
            acc    = '0;
        end
    endtask

    // Track register writes, predict on byte transfers, compare results
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_lo = '0;
            alpha_hi = '0;
            radix    = '0;
            scan     = SCAN_BLANKS;
            negate   = 1'b0;
            acc      = '0;
            expected_q.delete();
            errors   = 0;
            mismatches   <= 0;
            results_owed <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_ALPHA_LOW:  alpha_lo = cfg_data;
                    REG_ALPHA_HIGH: alpha_hi = cfg_data;
                    REG_BASE_LEN:   radix    = cfg_data[LEN_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                absorb_char(in_data);
            if (out_valid && !out_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected result value %0d invalid %0b",
                             $time, out_data.value, out_data.base_invalid);
                    errors++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (out_data.value !== want.value)
                    begin
                        $display("%0t: value expected %0d got %0d",
                                 $time, want.value, out_data.value);
                        errors++;
                    end
                    if (out_data.base_invalid !== want.base_invalid)
                    begin
                        $display("%0t: base_invalid expected %0b got %0b",
                                 $time, want.base_invalid, out_data.base_invalid);
                        errors++;
                    end
                end
            end
            mismatches   <= errors;
            results_owed <= expected_q.size();
        end
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench top of the radix string-to-integer converter. It programs a
// series of valid and invalid alphabets, sends directed and random strings
// byte by byte with random gaps and result stalls, and reports the verdict
// from the checker's mismatch and owed-result counts.
// ----------------------------------------------------------------------------
module tb;
    import bsi_pkg::*;

    localparam int QUIET_LIMIT = 1000;
    localparam int CHARS_PER_PHASE = 90;
    localparam int NUM_PHASES = 18;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [ALPHA_W-1:0]   cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    bsi_in_t              in_data;
    logic                 out_valid;
    logic                 out_stall;
    bsi_out_t             out_data;

    int mismatches;
    int results_owed;

    // Stimulus view of the current alphabet
    logic [CHAR_W-1:0] glyph [MAX_RADIX];
    int                radix_now;
    bit                steady;
    int                chars_sent;
    int                quiet_cycles;

    base_string_to_integer_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    bsi_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_data      (in_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_data     (out_data),
        .mismatches   (mismatches),
        .results_owed (results_owed)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Result side stalls at random, except during the steady phase
    always @(negedge clk)
        out_stall <= !steady && ($urandom_range(99) < 14);

    // Watchdog: too long without any transfer ends the run
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [ALPHA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic program_alphabet(input logic [ALPHA_W-1:0] lo,
                                    input logic [ALPHA_W-1:0] hi,
                                    input logic [LEN_W-1:0] len);
        write_reg(REG_ALPHA_LOW, lo);
        write_reg(REG_ALPHA_HIGH, hi);
        write_reg(REG_BASE_LEN, ALPHA_W'(len));
        for (int k = 0; k < MAX_RADIX; k++)
            glyph[k] = (k < 8) ? lo[k * 8 +: 8] : hi[(k - 8) * 8 +: 8];
        radix_now = int'(len);
    endtask

    // Distinct, legal characters in the used positions; junk elsewhere
    task automatic program_random_alphabet(input int len);
        logic [CHAR_W-1:0]  pick;
        bit                 taken [256];
        logic [ALPHA_W-1:0] lo;
        logic [ALPHA_W-1:0] hi;
        lo = {$urandom, $urandom};
        hi = {$urandom, $urandom};
        for (int k = 0; k < len; k++)
        begin
            do pick = CHAR_W'($urandom_range(1, 255));
            while (pick == CH_PLUS || pick == CH_MINUS || taken[pick]);
            taken[pick] = 1'b1;
            if (k < 8)
                lo[k * 8 +: 8] = pick;
            else
                hi[(k - 8) * 8 +: 8] = pick;
        end
        program_alphabet(lo, hi, LEN_W'(len));
    endtask

    // One byte transfer, with random gaps before it
    task automatic push_char(input logic [CHAR_W-1:0] c, input logic last);
        @(negedge clk);
        while (!steady && $urandom_range(99) < 14)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid          <= 1'b1;
        in_data.char_code <= c;
        in_data.is_last   <= last;
        do @(posedge clk); while (in_stall);
        chars_sent++;
    endtask

    task automatic send_text(input string text, input bit mark_last);
        for (int i = 0; i < text.len(); i++)
            push_char(text[i], mark_last && i == text.len() - 1);
    endtask

    // Stop sending until every outstanding result has come out
    task automatic hold_for_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (results_owed != 0)
            @(posedge clk);
    endtask

    // Quiet point for register writes: also lets the pipeline empty
    task automatic drain();
        hold_for_results();
        repeat (4) @(posedge clk);
    endtask

    // Mostly well-formed numbers with random content, the rest noise
    task automatic send_random_string();
        logic [CHAR_W-1:0] text [$];
        int                span;
        bit                zero_end;
        if ($urandom_range(99) < 75)
        begin
            span = (radix_now > MAX_RADIX) ? MAX_RADIX : radix_now;
            repeat ($urandom_range(0, 3))
                text.push_back(($urandom_range(5) == 5) ? CH_SPACE :
                               CH_TAB + CHAR_W'($urandom_range(4)));
            repeat ($urandom_range(0, 3))
                text.push_back($urandom_range(1) ? CH_MINUS : CH_PLUS);
            repeat (($urandom_range(9) == 0) ? $urandom_range(10, 14) :
                    $urandom_range(1, 8))
                text.push_back((span == 0 || $urandom_range(19) == 0) ?
                               CHAR_W'($urandom) : glyph[$urandom_range(span - 1)]);
            if ($urandom_range(4) == 0)
                repeat ($urandom_range(1, 3))
                    text.push_back(CHAR_W'($urandom));
        end
        else
        begin
            repeat ($urandom_range(1, 8))
                text.push_back(CHAR_W'($urandom));
        end
        zero_end = bit'($urandom_range(1));
        if (zero_end)
            text.push_back(CH_NUL);
        for (int i = 0; i < text.size(); i++)
        begin
            if (i < text.size() - 1)
                push_char(text[i], 1'b0);
            else
                push_char(text[i], zero_end ? logic'($urandom_range(1)) : 1'b1);
        end
        if ($urandom_range(49) == 0)
            hold_for_results();
    endtask

    // Alphabet of each phase: valid sets, every invalid kind, random sets
    task automatic setup_phase(input int s);
        case (s)
            0:  program_alphabet(64'h3736353433323130, 64'h0000000000003938, 5'd10);
            1:  program_alphabet(64'h3736353433323130, 64'h6665646362613938, 5'd16);
            2:  program_alphabet({$urandom, 16'h0000, 16'h3130} | 64'h0,
                                 {$urandom, $urandom}, 5'd2);
            3:  program_alphabet(64'h3736353433323130, 64'h0000000000003938, 5'd0);
            4:  program_alphabet(64'h3736353433323130, 64'h6665646362613938, 5'd31);
            5:  program_alphabet(64'h3736353433323130, 64'h0000000000003938, 5'd1);
            6:  program_alphabet(64'h37363534332B3130, 64'h0000000000003938, 5'd10);
            7:  program_alphabet(64'h3736352D33323130, 64'h0000000000003938, 5'd10);
            8:  program_alphabet(64'h3736353433303130, 64'h0000000000003938, 5'd10);
            9:  program_alphabet(64'h3736353433323130, 64'h0000000000000038, 5'd10);
            10: program_alphabet({64{1'b1}}, {64{1'b1}}, 5'd16);
            // repeats only in unused positions leave the alphabet valid
            11: program_alphabet(64'h3736353433323130, 64'h3030303030303938, 5'd10);
            16, 17: program_alphabet({$urandom, $urandom}, {$urandom, $urandom},
                                     LEN_W'($urandom_range(0, 31)));
            default: program_random_alphabet(int'($urandom_range(2, MAX_RADIX)));
        endcase
    endtask

    initial
    begin
        int quota;
        clk       = 1'b0;
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        in_data   = '0;
        out_stall = 1'b0;
        steady    = 1'b0;
        radix_now = 0;
        chars_sent = 0;
        quiet_cycles = 0;
        for (int k = 0; k < MAX_RADIX; k++)
            glyph[k] = '0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int s = 0; s < NUM_PHASES; s++)
        begin
            setup_phase(s);
            steady = (s == 2);
            if (s == 0)
            begin
                // sign run, whitespace, extreme bytes, early stop, wrap
                send_text(" -+-42", 1'b1);
                push_char(CH_TAB, 1'b0);
                push_char(CH_CR, 1'b0);
                push_char(CH_MINUS, 1'b0);
                push_char("9", 1'b0);
                push_char(CH_NUL, 1'b0);
                push_char(8'hFF, 1'b1);
                send_text("12a3", 1'b1);
                send_text("4999999999", 1'b1);
                hold_for_results();
            end
            quota = chars_sent + CHARS_PER_PHASE;
            while (chars_sent < quota)
                send_random_string();
            drain();
        end

        if (mismatches == 0 && results_owed == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
